/* rtl/tdpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time of day palette tint package
// Shared types, register indexes, enable masks and the built-in filter tables.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int unsigned CSR_DATA_W = 6;

   typedef logic [14:0] rgb555_type;

   typedef enum logic [2:0] {
      CSR_HOUR_OF_DAY      = 3'd0,
      CSR_MINUTE_OF_HOUR   = 3'd1,
      CSR_BATTLE_MODE      = 3'd2,
      CSR_DAWN_START       = 3'd3,
      CSR_MORNING_START    = 3'd4,
      CSR_AFTERNOON_START  = 3'd5,
      CSR_NIGHT_START      = 3'd6,
      CSR_LATE_NIGHT_START = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [4:0] hour_of_day;
      logic [5:0] minute_of_hour;
      logic       battle_mode;
      logic [4:0] dawn_start;
      logic [4:0] morning_start;
      logic [4:0] afternoon_start;
      logic [4:0] night_start;
      logic [4:0] late_night_start;
   } cfg_type;

   // Bit n set means palette n is enabled for tinting.
   localparam logic [31:0] OW_ENABLE     = 32'hFFFF_1FFF;
   localparam logic [31:0] BATTLE_ENABLE = 32'h0000_FCDC;

   localparam int unsigned TAG_EXCEPT_N = 11;
   localparam logic [15:0] TAG_EXCEPT [TAG_EXCEPT_N] = '{
      16'h0066, 16'hD750, 16'h1075, 16'h1078, 16'h1088, 16'h1089,
      16'h108A, 16'h108B, 16'hDAC0, 16'hDAC1, 16'hDAC2
   };

   function automatic rgb555_type pk(input logic [4:0] r, input logic [4:0] g,
                                     input logic [4:0] b);
      return {b, g, r};
   endfunction

   localparam rgb555_type NIGHT_FILTER = {5'd6, 5'd14, 5'd14};

   function automatic logic is_tag_exception(input logic [15:0] tag);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < TAG_EXCEPT_N; i++) begin
         if (TAG_EXCEPT[i] == tag) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic rgb555_type midnight_filter(input logic [2:0] idx);
      rgb555_type f;
      unique case (idx)
         3'd0:    f = pk(5'd14, 5'd14, 5'd6);
         3'd1:    f = pk(5'd14, 5'd14, 5'd7);
         3'd2:    f = pk(5'd14, 5'd14, 5'd8);
         3'd3:    f = pk(5'd15, 5'd15, 5'd8);
         3'd4:    f = pk(5'd15, 5'd15, 5'd9);
         3'd5:    f = pk(5'd15, 5'd15, 5'd9);
         3'd6:    f = pk(5'd16, 5'd16, 5'd9);
         default: f = pk(5'd16, 5'd16, 5'd10);
      endcase
      return f;
   endfunction

   function automatic rgb555_type dawn_filter(input logic [4:0] idx);
      rgb555_type f;
      unique case (idx)
         5'd0:    f = pk(5'd15, 5'd15, 5'd10);
         5'd1:    f = pk(5'd15, 5'd15, 5'd10);
         5'd2:    f = pk(5'd14, 5'd14, 5'd10);
         5'd3:    f = pk(5'd13, 5'd13, 5'd10);
         5'd4:    f = pk(5'd12, 5'd12, 5'd10);
         5'd5:    f = pk(5'd11, 5'd11, 5'd10);
         5'd6:    f = pk(5'd10, 5'd10, 5'd10);
         5'd7:    f = pk(5'd9,  5'd9,  5'd10);
         5'd8:    f = pk(5'd8,  5'd8,  5'd10);
         5'd9:    f = pk(5'd8,  5'd8,  5'd11);
         5'd10:   f = pk(5'd7,  5'd7,  5'd11);
         5'd11:   f = pk(5'd6,  5'd6,  5'd11);
         5'd12:   f = pk(5'd5,  5'd5,  5'd11);
         5'd13:   f = pk(5'd4,  5'd4,  5'd11);
         5'd14:   f = pk(5'd3,  5'd3,  5'd11);
         5'd15:   f = pk(5'd2,  5'd2,  5'd11);
         5'd16:   f = pk(5'd1,  5'd1,  5'd11);
         5'd17:   f = pk(5'd0,  5'd0,  5'd11);
         5'd18:   f = pk(5'd0,  5'd0,  5'd10);
         5'd19:   f = pk(5'd0,  5'd0,  5'd9);
         5'd20:   f = pk(5'd0,  5'd0,  5'd8);
         5'd21:   f = pk(5'd0,  5'd0,  5'd7);
         5'd22:   f = pk(5'd0,  5'd0,  5'd6);
         5'd23:   f = pk(5'd0,  5'd0,  5'd5);
         5'd24:   f = pk(5'd0,  5'd0,  5'd4);
         5'd25:   f = pk(5'd0,  5'd0,  5'd3);
         5'd26:   f = pk(5'd0,  5'd0,  5'd2);
         5'd27:   f = pk(5'd0,  5'd0,  5'd1);
         default: f = pk(5'd0,  5'd0,  5'd0);
      endcase
      return f;
   endfunction

   function automatic rgb555_type sunset_filter(input logic [4:0] idx);
      rgb555_type f;
      unique case (idx)
         5'd0:    f = pk(5'd0, 5'd0,  5'd1);
         5'd1:    f = pk(5'd0, 5'd1,  5'd1);
         5'd2:    f = pk(5'd0, 5'd1,  5'd2);
         5'd3:    f = pk(5'd0, 5'd1,  5'd3);
         5'd4:    f = pk(5'd0, 5'd2,  5'd3);
         5'd5:    f = pk(5'd0, 5'd2,  5'd4);
         5'd6:    f = pk(5'd0, 5'd2,  5'd5);
         5'd7:    f = pk(5'd0, 5'd3,  5'd5);
         5'd8:    f = pk(5'd0, 5'd3,  5'd6);
         5'd9:    f = pk(5'd0, 5'd3,  5'd7);
         5'd10:   f = pk(5'd0, 5'd4,  5'd7);
         5'd11:   f = pk(5'd0, 5'd4,  5'd8);
         5'd12:   f = pk(5'd0, 5'd4,  5'd9);
         5'd13:   f = pk(5'd0, 5'd5,  5'd9);
         5'd14:   f = pk(5'd0, 5'd5,  5'd10);
         5'd15:   f = pk(5'd0, 5'd5,  5'd11);
         5'd16:   f = pk(5'd0, 5'd6,  5'd11);
         5'd17:   f = pk(5'd0, 5'd6,  5'd12);
         5'd18:   f = pk(5'd0, 5'd6,  5'd13);
         5'd19:   f = pk(5'd0, 5'd7,  5'd13);
         5'd20:   f = pk(5'd0, 5'd7,  5'd14);
         5'd21:   f = pk(5'd0, 5'd7,  5'd14);
         5'd22:   f = pk(5'd0, 5'd8,  5'd14);
         5'd23:   f = pk(5'd0, 5'd9,  5'd14);
         5'd24:   f = pk(5'd0, 5'd10, 5'd14);
         5'd25:   f = pk(5'd0, 5'd11, 5'd14);
         5'd26:   f = pk(5'd0, 5'd12, 5'd14);
         5'd27:   f = pk(5'd0, 5'd13, 5'd14);
         default: f = pk(5'd0, 5'd14, 5'd14);
      endcase
      return f;
   endfunction

   function automatic rgb555_type nightfall_filter(input logic [4:0] idx);
      rgb555_type f;
      unique case (idx)
         5'd0:    f = pk(5'd0,  5'd14, 5'd14);
         5'd1:    f = pk(5'd0,  5'd14, 5'd14);
         5'd2:    f = pk(5'd0,  5'd14, 5'd13);
         5'd3:    f = pk(5'd0,  5'd14, 5'd12);
         5'd4:    f = pk(5'd0,  5'd14, 5'd11);
         5'd5:    f = pk(5'd0,  5'd14, 5'd10);
         5'd6:    f = pk(5'd1,  5'd14, 5'd10);
         5'd7:    f = pk(5'd1,  5'd14, 5'd9);
         5'd8:    f = pk(5'd0,  5'd14, 5'd8);
         5'd9:    f = pk(5'd1,  5'd14, 5'd7);
         5'd10:   f = pk(5'd1,  5'd14, 5'd6);
         5'd11:   f = pk(5'd2,  5'd14, 5'd6);
         5'd12:   f = pk(5'd2,  5'd14, 5'd5);
         5'd13:   f = pk(5'd2,  5'd14, 5'd4);
         5'd14:   f = pk(5'd2,  5'd14, 5'd3);
         5'd15:   f = pk(5'd2,  5'd14, 5'd2);
         5'd16:   f = pk(5'd2,  5'd14, 5'd2);
         5'd17:   f = pk(5'd3,  5'd14, 5'd3);
         5'd18:   f = pk(5'd4,  5'd14, 5'd4);
         5'd19:   f = pk(5'd5,  5'd14, 5'd5);
         5'd20:   f = pk(5'd6,  5'd14, 5'd6);
         5'd21:   f = pk(5'd7,  5'd14, 5'd6);
         5'd22:   f = pk(5'd8,  5'd14, 5'd6);
         5'd23:   f = pk(5'd9,  5'd14, 5'd6);
         5'd24:   f = pk(5'd10, 5'd14, 5'd6);
         5'd25:   f = pk(5'd11, 5'd14, 5'd6);
         5'd26:   f = pk(5'd12, 5'd14, 5'd6);
         5'd27:   f = pk(5'd13, 5'd14, 5'd6);
         default: f = pk(5'd14, 5'd14, 5'd6);
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

/* rtl/tdpt_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time of day palette tint channels
// Valid/ready channels for the colour request and the tinted response.
// ----------------------------------------------------------------------------
interface tdpt_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  palette_index;
   logic [3:0]  colour_index;
   logic [14:0] colour_in;
   logic [15:0] palette_tag;

   modport source (output valid, output palette_index, output colour_index,
                   output colour_in, output palette_tag, input ready);
   modport sink   (input valid, input palette_index, input colour_index,
                   input colour_in, input palette_tag, output ready);
endinterface

interface tdpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  colour_slot;
   logic [14:0] colour_out;
   logic        was_tinted;

   modport source (output valid, output colour_slot, output colour_out,
                   output was_tinted, input ready);
   modport sink   (input valid, input colour_slot, input colour_out,
                   input was_tinted, output ready);
endinterface
`default_nettype wire

/* rtl/tdpt_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time of day filter select
// Maps the configured hour and minute to a time band and its filter colour.
// ----------------------------------------------------------------------------
module tdpt_filter (
   input  tdpt_pkg::cfg_type    cfg,
   output tdpt_pkg::rgb555_type filter
);
   import tdpt_pkg::*;

   typedef enum logic [2:0] {
      BAND_MIDNIGHT,
      BAND_DAWN,
      BAND_DAY,
      BAND_SUNSET,
      BAND_NIGHTFALL,
      BAND_NIGHT
   } band_type;

   band_type   band;
   logic [4:0] half;
   logic [2:0] mid_idx;

   // Thresholds are checked in order as written, so any setting picks one band.
   always_comb begin
      priority if (cfg.hour_of_day < cfg.dawn_start)       band = BAND_MIDNIGHT;
      else if (cfg.hour_of_day < cfg.morning_start)        band = BAND_DAWN;
      else if (cfg.hour_of_day < cfg.afternoon_start)      band = BAND_DAY;
      else if (cfg.hour_of_day < cfg.night_start)          band = BAND_SUNSET;
      else if (cfg.hour_of_day < cfg.late_night_start)     band = BAND_NIGHTFALL;
      else                                                 band = BAND_NIGHT;
   end

   // Half-minute index saturates at the last of the thirty entries.
   assign half    = (cfg.minute_of_hour[5:1] > 5'd29) ? 5'd29 : cfg.minute_of_hour[5:1];
   assign mid_idx = (cfg.hour_of_day == 5'd0) ? cfg.minute_of_hour[5:3] : 3'd7;

   always_comb begin
      unique case (band)
         BAND_MIDNIGHT:  filter = midnight_filter(mid_idx);
         BAND_DAWN:      filter = dawn_filter(half);
         BAND_DAY:       filter = '0;
         BAND_SUNSET:    filter = sunset_filter(half);
         BAND_NIGHTFALL: filter = nightfall_filter(half);
         BAND_NIGHT:     filter = NIGHT_FILTER;
         default:        filter = '0;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/tdpt_shade.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time of day shade datapath
// Decides whether a palette is tinted and scales the three channels.
// ----------------------------------------------------------------------------
module tdpt_shade (
   input  logic [4:0]           palette_index,
   input  logic [15:0]          palette_tag,
   input  tdpt_pkg::rgb555_type colour_in,
   input  tdpt_pkg::rgb555_type filter,
   input  logic                 battle_mode,
   output tdpt_pkg::rgb555_type colour_out,
   output logic                 tinted
);
   import tdpt_pkg::*;

   logic [31:0] enable_mask;
   logic        enabled;
   rgb555_type  scaled;

   assign enable_mask = battle_mode ? BATTLE_ENABLE : OW_ENABLE;
   assign enabled     = enable_mask[palette_index];

   // Sprite palettes whose tag is on the exception list are left alone.
   assign tinted = enabled && !(palette_index[4] && is_tag_exception(palette_tag));

   // Each channel becomes c * (31 - f) >> 5; three small multipliers in parallel.
   always_comb begin
      logic [4:0] chan;
      logic [4:0] gain;
      logic [9:0] prod;
      scaled = '0;
      for (int ch = 0; ch < 3; ch++) begin
         chan = colour_in[ch*5 +: 5];
         gain = 5'd31 - filter[ch*5 +: 5];
         prod = chan * gain;
         scaled[ch*5 +: 5] = prod[9:5];
      end
   end

   assign colour_out = tinted ? scaled : colour_in;

endmodule
`default_nettype wire

/* rtl/time_of_day_palette_tint.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time of day palette tint
// Tints one 5-5-5 palette colour per beat by the configured time of day.
// ----------------------------------------------------------------------------
// Usage:
//   The req_bus channel carries one palette colour per beat with its palette
//   number, colour number and sprite palette tag. The rsp_bus channel returns
//   one beat for every request: the colour slot, the tinted or unchanged
//   colour, and a flag telling whether the tint was applied.
//   The csr_ port writes the clock hour, minute, battle mode and the five band
//   thresholds; the user must write it only while no beats are in flight, as
//   the block itself does not enforce this. After a request is accepted it
//   sits in the input register while the band lookup and three 5x5 multiplies
//   feed the response register, which then presents the response beat.
//   Throughput is one beat per cycle while the receiver takes responses, set
//   by the two-deep register pipeline.
//   When the receiver stalls, the response register holds its beat and the
//   input register keeps accepting until it too is full, so two beats can be
//   buffered before req_bus.ready drops.
//   Reset empties both registers and loads the configuration defaults: noon,
//   minute zero, overworld mode and thresholds 4, 6, 17, 19 and 22.
// ----------------------------------------------------------------------------
module time_of_day_palette_tint (
   input  logic                        clock,
   input  logic                        reset,
   tdpt_req_if.sink                    req_bus,
   tdpt_rsp_if.source                  rsp_bus,
   input  logic                        csr_wr_en,
   input  tdpt_pkg::csr_index_type     csr_index,
   input  logic [tdpt_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import tdpt_pkg::*;

   // Configuration registers.
   cfg_type cfg_ff;

   // Input register stage.
   logic        a_valid_ff;
   logic [4:0]  a_pal_ff;
   logic [3:0]  a_col_ff;
   rgb555_type  a_colour_ff;
   logic [15:0] a_tag_ff;

   // Response register stage.
   logic        b_valid_ff;
   logic [8:0]  b_slot_ff;
   rgb555_type  b_colour_ff;
   logic        b_tinted_ff;

   logic        b_free;
   logic        a_free;
   logic        a_load;
   logic        b_load;
   rgb555_type  filter;
   rgb555_type  shade_colour;
   logic        shade_tinted;

   // The response register frees up when empty or when its beat is taken;
   // the input register frees up when empty or when it can move forward.
   assign b_free = !b_valid_ff || rsp_bus.ready;
   assign a_free = !a_valid_ff || b_free;
   assign a_load = req_bus.valid && a_free;
   assign b_load = a_valid_ff && b_free;

   assign req_bus.ready = a_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hour_of_day      <= 5'd12;
         cfg_ff.minute_of_hour   <= 6'd0;
         cfg_ff.battle_mode      <= 1'b0;
         cfg_ff.dawn_start       <= 5'd4;
         cfg_ff.morning_start    <= 5'd6;
         cfg_ff.afternoon_start  <= 5'd17;
         cfg_ff.night_start      <= 5'd19;
         cfg_ff.late_night_start <= 5'd22;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HOUR_OF_DAY:      cfg_ff.hour_of_day      <= csr_wr_data[4:0];
            CSR_MINUTE_OF_HOUR:   cfg_ff.minute_of_hour   <= csr_wr_data[5:0];
            CSR_BATTLE_MODE:      cfg_ff.battle_mode      <= csr_wr_data[0];
            CSR_DAWN_START:       cfg_ff.dawn_start       <= csr_wr_data[4:0];
            CSR_MORNING_START:    cfg_ff.morning_start    <= csr_wr_data[4:0];
            CSR_AFTERNOON_START:  cfg_ff.afternoon_start  <= csr_wr_data[4:0];
            CSR_NIGHT_START:      cfg_ff.night_start      <= csr_wr_data[4:0];
            CSR_LATE_NIGHT_START: cfg_ff.late_night_start <= csr_wr_data[4:0];
            default: ;
         endcase
      end
   end

   // Valid flags of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_free) a_valid_ff <= req_bus.valid;
         if (b_free) b_valid_ff <= a_valid_ff;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_pal_ff    <= req_bus.palette_index;
         a_col_ff    <= req_bus.colour_index;
         a_colour_ff <= req_bus.colour_in;
         a_tag_ff    <= req_bus.palette_tag;
      end
      if (b_load) begin
         b_slot_ff   <= {a_pal_ff, a_col_ff};
         b_colour_ff <= shade_colour;
         b_tinted_ff <= shade_tinted;
      end
   end

   // Band and filter follow the configuration registers directly; they are
   // static while beats flow only if the user writes no configuration then.
   tdpt_filter u_filter (
      .cfg    (cfg_ff),
      .filter (filter)
   );

   tdpt_shade u_shade (
      .palette_index (a_pal_ff),
      .palette_tag   (a_tag_ff),
      .colour_in     (a_colour_ff),
      .filter        (filter),
      .battle_mode   (cfg_ff.battle_mode),
      .colour_out    (shade_colour),
      .tinted        (shade_tinted)
   );

   assign rsp_bus.valid       = b_valid_ff;
   assign rsp_bus.colour_slot = b_slot_ff;
   assign rsp_bus.colour_out  = b_colour_ff;
   assign rsp_bus.was_tinted  = b_tinted_ff;

   // A beat waiting in the input register is not dropped while the output stalls.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_free |=> a_valid_ff)
      else $error("input stage beat lost during output stall");

   // Backpressure reaches the requester only when both stages are full.
   ready_low_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> a_valid_ff && b_valid_ff)
      else $error("request ready low with a free stage");

   // The slot is the palette and colour numbers of the beat that moved forward.
   slot_follows_input: assert property (@(posedge clock) disable iff (reset)
      b_load |=> rsp_bus.colour_slot == {$past(a_pal_ff), $past(a_col_ff)})
      else $error("colour slot does not match its source beat");

   // An untinted response carries the source colour unchanged.
   pass_through_exact: assert property (@(posedge clock) disable iff (reset)
      b_load && !shade_tinted |=> rsp_bus.colour_out == $past(a_colour_ff))
      else $error("passed-through colour was altered");

   // Scaling by at most 31/32 keeps every tinted channel below full scale.
   tinted_below_full: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.was_tinted |->
         rsp_bus.colour_out[4:0] != 5'd31 && rsp_bus.colour_out[9:5] != 5'd31 &&
         rsp_bus.colour_out[14:10] != 5'd31)
      else $error("tinted channel reached full scale");

endmodule
`default_nettype wire
